// File: design/pacc_pkg.sv
// Shared types and constants for the pedal assist current calculator.
package pacc_pkg;

    // Fixed arithmetic constants.
    localparam logic [18:0] TWO_PI_Q16    = 19'd411775;
    localparam logic [8:0]  RIDER_CAP     = 9'd500;
    localparam logic [16:0] FACTOR_MAX    = 17'd16384;
    localparam logic [12:0] RPM_THRESHOLD = 13'd10;
    localparam logic [25:0] MA_PER_W_HI   = 26'd61440000;
    localparam logic [13:0] MA_PER_W_LO   = 14'd10000;

    // Quotient width of both divider pipelines.
    localparam int QUO_W = 16;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SPEED_POINTS = 3'd0,
        CFG_ASSIST_ROW   = 3'd1,
        CFG_MAX_POWER    = 3'd2,
        CFG_TORQUE_CONST = 3'd3,
        CFG_BATT_VOLTAGE = 3'd4,
        CFG_MAX_CURRENT  = 3'd5,
        CFG_MIN_CURRENT  = 3'd6
    } t_cfg_idx;

    // Configuration register set.
    typedef struct packed {
        logic [63:0] speed_points;
        logic [63:0] assist_row;
        logic [11:0] max_power;
        logic [12:0] torque_constant;
        logic [9:0]  battery_voltage;
        logic [15:0] max_current;
        logic [15:0] min_current;
    } t_cfg;

    // One classified sample handed from the front to the back.
    typedef struct packed {
        logic [14:0] factor;
        logic [8:0]  rider;
        logic [12:0] rpm;
    } t_item;

endpackage

// File: design/pedal_assist_current_calc_core.sv
// Top level of the pedal assist current calculator.
// The block takes one sample beat per clock cycle while o_in_stall is low and returns
// one result beat per sample, in order. A front pipeline computes rider power and the
// interpolated assist factor (stage 1 and 2 registers, a 16-stage divider for the
// interpolation step and a holding stage), a four-entry queue follows, and a back
// pipeline computes assist power and motor current (stage 1 to 4 registers, a 16-stage
// divider and the output register). Both dividers are fully pipelined.
// Configuration registers are written through the plain write port while idle; the
// user must keep to this, as the block does not enforce it.
module pedal_assist_current_calc_core
    import pacc_pkg::*;
#(
    parameter int NUM_POINTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_torque,
    input  logic [11:0] i_cadence,
    input  logic [10:0] i_road_speed,
    input  logic        i_speed_valid,
    input  logic [12:0] i_motor_speed,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_target_current,
    output logic [14:0] o_assist_factor,
    output logic [8:0]  o_rider_power,
    output logic [11:0] o_assist_power
);

    // Configuration registers.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_points    <= 64'd0;
            r_cfg.assist_row      <= 64'd0;
            r_cfg.max_power       <= 12'd250;
            r_cfg.torque_constant <= 13'd1464;
            r_cfg.battery_voltage <= 10'd360;
            r_cfg.max_current     <= 16'd15000;
            r_cfg.min_current     <= 16'd500;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SPEED_POINTS: r_cfg.speed_points    <= i_cfg_wr_data;
                CFG_ASSIST_ROW:   r_cfg.assist_row      <= i_cfg_wr_data;
                CFG_MAX_POWER:    r_cfg.max_power       <= i_cfg_wr_data[11:0];
                CFG_TORQUE_CONST: r_cfg.torque_constant <= i_cfg_wr_data[12:0];
                CFG_BATT_VOLTAGE: r_cfg.battery_voltage <= i_cfg_wr_data[9:0];
                CFG_MAX_CURRENT:  r_cfg.max_current     <= i_cfg_wr_data[15:0];
                CFG_MIN_CURRENT:  r_cfg.min_current     <= i_cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Front, queue and back.
    logic  q_push;
    t_item q_in;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    t_item q_out;

    pacc_front #(
        .NUM_POINTS (NUM_POINTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_torque      (i_torque),
        .i_cadence     (i_cadence),
        .i_road_speed  (i_road_speed),
        .i_speed_valid (i_speed_valid),
        .i_motor_speed (i_motor_speed),
        .o_push        (q_push),
        .o_item        (q_in),
        .i_full        (q_full)
    );

    pacc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out)
    );

    pacc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (q_valid),
        .i_q_item         (q_out),
        .o_pop            (q_pop),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_target_current (o_target_current),
        .o_assist_factor  (o_assist_factor),
        .o_rider_power    (o_rider_power),
        .o_assist_power   (o_assist_power)
    );

    // Result beats stay inside their documented ranges.
    a_rider_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_rider_power <= RIDER_CAP)
        else $error("rider power above cap");

    a_factor_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> {2'b0, o_assist_factor} <= FACTOR_MAX)
        else $error("assist factor above 4.0");

    a_power_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_assist_power <= r_cfg.max_power)
        else $error("assist power above configured cap");

    a_zero_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_assist_power == '0) |-> o_target_current == '0)
        else $error("nonzero current without assist power");

endmodule

// File: design/pacc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
module pacc_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 16,
    parameter int QW    = 16,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [QW-1:0]    o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [DEN_W-1:0] r_rem [QW];
    logic [QW-1:0]    r_dq  [QW];
    logic [DEN_W-1:0] r_den [QW];
    logic [TAG_W-1:0] r_tag [QW];
    logic             r_vld [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [QW-1:0]    dq_in;
        logic [DEN_W-1:0] den_in;
        logic [TAG_W-1:0] tag_in;
        logic             vld_in;
        logic [DEN_W:0]   sh;
        logic             ge;
        logic [DEN_W-1:0] n_rem;

        // The first stage starts from the upper dividend bits; the quotient
        // is known to fit, so they stay below the divisor.
        if (g == 0) begin : g_first
            assign rem_in = DEN_W'(i_num >> QW);
            assign dq_in  = i_num[QW-1:0];
            assign den_in = i_den;
            assign tag_in = i_tag;
            assign vld_in = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign dq_in  = r_dq[g-1];
            assign den_in = r_den[g-1];
            assign tag_in = r_tag[g-1];
            assign vld_in = r_vld[g-1];
        end

        // Bring down one bit, then trial subtract.
        assign sh    = {rem_in, dq_in[QW-1]};
        assign ge    = sh >= {1'b0, den_in};
        assign n_rem = ge ? DEN_W'(sh - {1'b0, den_in}) : sh[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_dq[g]  <= {dq_in[QW-2:0], ge};
                r_den[g] <= den_in;
                r_tag[g] <= tag_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_dq[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

// File: design/pacc_front.sv
// Front: rider power and speed-indexed assist factor with interpolation.
module pacc_front
    import pacc_pkg::*;
#(
    parameter int NUM_POINTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_torque,
    input  logic [11:0] i_cadence,
    input  logic [10:0] i_road_speed,
    input  logic        i_speed_valid,
    input  logic [12:0] i_motor_speed,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_full
);

    localparam int IDX_W = $clog2(NUM_POINTS);
    localparam int TAG_W = 9 + 16 + 1 + 1 + 13;

    logic en;

    logic [15:0] w_pt [NUM_POINTS];
    logic [15:0] w_af [NUM_POINTS];

    for (genvar g = 0; g < NUM_POINTS; g++) begin : g_unpack
        assign w_pt[g] = i_cfg.speed_points[16*g +: 16];
        assign w_af[g] = i_cfg.assist_row[16*g +: 16];
    end

    // Stage 1: interval search and interpolation operands.
    logic [15:0]      s16;
    logic             n_found;
    logic [IDX_W-1:0] n_lo;
    logic [IDX_W-1:0] n_hi;
    logic [15:0]      n_slo;
    logic [15:0]      n_shi;
    logic [15:0]      n_ahi;
    logic [15:0]      n_alo;
    logic             n_direct;
    logic [16:0]      n_delta;

    assign s16 = {5'd0, i_road_speed};

    always_comb begin
        n_found = 1'b0;
        n_lo    = '0;
        for (int i = 0; i < NUM_POINTS - 1; i++) begin
            if (!n_found && s16 >= w_pt[i] && s16 <= w_pt[i+1]) begin
                n_found = 1'b1;
                n_lo    = IDX_W'(i);
            end
        end
        n_hi  = n_found ? IDX_W'(n_lo + 1'b1) : IDX_W'(NUM_POINTS - 1);
        n_slo = w_pt[n_lo];
        n_shi = w_pt[n_hi];
        n_ahi = w_af[n_hi];
        if (!i_speed_valid || s16 <= w_pt[0]) begin
            n_direct = 1'b1;
            n_alo    = w_af[0];
        end else if (s16 >= w_pt[NUM_POINTS-1]) begin
            n_direct = 1'b1;
            n_alo    = w_af[NUM_POINTS-1];
        end else if (n_shi <= n_slo || s16 < n_slo) begin
            n_direct = 1'b1;
            n_alo    = w_af[n_lo];
        end else begin
            n_direct = 1'b0;
            n_alo    = w_af[n_lo];
        end
        n_delta = {1'b0, n_ahi} - {1'b0, n_alo};
    end

    logic        r_f1_vld;
    logic [27:0] r_f1_tc;
    logic [15:0] r_f1_alo;
    logic        r_f1_neg;
    logic        r_f1_direct;
    logic [10:0] r_f1_d;
    logic [15:0] r_f1_mag;
    logic [15:0] r_f1_w;
    logic [12:0] r_f1_rpm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (en) begin
            r_f1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_tc     <= i_torque * i_cadence;
            r_f1_alo    <= n_alo;
            r_f1_neg    <= n_delta[16];
            r_f1_direct <= n_direct;
            r_f1_d      <= 11'(s16 - n_slo);
            r_f1_mag    <= n_delta[16] ? 16'(-n_delta) : n_delta[15:0];
            r_f1_w      <= n_shi - n_slo;
            r_f1_rpm    <= i_motor_speed;
        end
    end

    // Stage 2: rider power and interpolation product.
    logic [46:0] n_pw;
    logic [14:0] n_pw_w;

    assign n_pw   = r_f1_tc * TWO_PI_Q16;
    assign n_pw_w = n_pw[46:32];

    logic        r_f2_vld;
    logic [8:0]  r_f2_rider;
    logic [26:0] r_f2_prod;
    logic [15:0] r_f2_w;
    logic [15:0] r_f2_alo;
    logic        r_f2_neg;
    logic        r_f2_direct;
    logic [12:0] r_f2_rpm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_vld <= 1'b0;
        end else if (en) begin
            r_f2_vld <= r_f1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2_rider  <= (n_pw_w > 15'(RIDER_CAP)) ? RIDER_CAP : n_pw_w[8:0];
            r_f2_prod   <= r_f1_d * r_f1_mag;
            r_f2_w      <= r_f1_w;
            r_f2_alo    <= r_f1_alo;
            r_f2_neg    <= r_f1_neg;
            r_f2_direct <= r_f1_direct;
            r_f2_rpm    <= r_f1_rpm;
        end
    end

    // Divider pipeline for the interpolation step.
    logic             div_vld;
    logic [QUO_W-1:0] div_q;
    logic [TAG_W-1:0] div_tag;

    pacc_div #(
        .NUM_W (27),
        .DEN_W (16),
        .QW    (QUO_W),
        .TAG_W (TAG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_f2_vld),
        .i_num   (r_f2_prod),
        .i_den   (r_f2_w),
        .i_tag   ({r_f2_rider, r_f2_alo, r_f2_neg, r_f2_direct, r_f2_rpm}),
        .o_valid (div_vld),
        .o_quo   (div_q),
        .o_tag   (div_tag)
    );

    // Stage 3: combine, clamp to 0..4.0 and hold for the queue.
    logic [8:0]  t_rider;
    logic [15:0] t_alo;
    logic        t_neg;
    logic        t_direct;
    logic [12:0] t_rpm;
    logic [16:0] n_f;

    assign {t_rider, t_alo, t_neg, t_direct, t_rpm} = div_tag;

    always_comb begin
        if (t_direct) begin
            n_f = {1'b0, t_alo};
        end else if (t_neg) begin
            n_f = (div_q > t_alo) ? 17'd0 : {1'b0, t_alo - div_q};
        end else begin
            n_f = {1'b0, t_alo} + {1'b0, div_q};
        end
    end

    logic  r_f3_vld;
    t_item r_f3_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_vld <= 1'b0;
        end else if (en) begin
            r_f3_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f3_item.factor <= (n_f > FACTOR_MAX) ? FACTOR_MAX[14:0] : n_f[14:0];
            r_f3_item.rider  <= t_rider;
            r_f3_item.rpm    <= t_rpm;
        end
    end

    // The front moves unless its finished beat cannot enter the queue.
    assign en      = !r_f3_vld || !i_full;
    assign o_stall = !en;
    assign o_push  = r_f3_vld && !i_full;
    assign o_item  = r_f3_item;

endmodule

// File: design/pacc_fifo.sv
// Short queue between the front and the back.
module pacc_fifo
    import pacc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= QPTR_W'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= QPTR_W'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= QCNT_W'(r_cnt + 1'b1);
            end else if (i_pop && !i_push) begin
                r_cnt <= QCNT_W'(r_cnt - 1'b1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// File: design/pacc_back.sv
// Back: assist power, motor current division and current limits.
module pacc_back
    import pacc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_target_current,
    output logic [14:0] o_assist_factor,
    output logic [8:0]  o_rider_power,
    output logic [11:0] o_assist_power
);

    localparam int NUM_W = 54;
    localparam int DEN_W = 45;
    localparam int TAG_W = 12 + 15 + 9 + 1;

    logic en;
    logic r_out_vld;

    assign en    = !r_out_vld || !i_stall;
    assign o_pop = en && i_q_valid;

    // Stage 1: assist power.
    logic [23:0] n_ap;

    assign n_ap = i_q_item.factor * i_q_item.rider;

    logic        r_b1_vld;
    logic [11:0] r_b1_pow;
    logic [14:0] r_b1_factor;
    logic [8:0]  r_b1_rider;
    logic [12:0] r_b1_rpm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
        end else if (en) begin
            r_b1_vld <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_pow    <= (n_ap[23:12] > i_cfg.max_power) ? i_cfg.max_power : n_ap[23:12];
            r_b1_factor <= i_q_item.factor;
            r_b1_rider  <= i_q_item.rider;
            r_b1_rpm    <= i_q_item.rpm;
        end
    end

    // Stage 2: partial products of numerator and denominator.
    logic        r_b2_vld;
    logic [37:0] r_b2_phi;
    logic [25:0] r_b2_plo;
    logic [25:0] r_b2_kr;
    logic        r_b2_hi;
    logic [11:0] r_b2_pow;
    logic [14:0] r_b2_factor;
    logic [8:0]  r_b2_rider;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_vld <= 1'b0;
        end else if (en) begin
            r_b2_vld <= r_b1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b2_phi    <= r_b1_pow * MA_PER_W_HI;
            r_b2_plo    <= r_b1_pow * MA_PER_W_LO;
            r_b2_kr     <= i_cfg.torque_constant * r_b1_rpm;
            r_b2_hi     <= r_b1_rpm > RPM_THRESHOLD;
            r_b2_pow    <= r_b1_pow;
            r_b2_factor <= r_b1_factor;
            r_b2_rider  <= r_b1_rider;
        end
    end

    // Stage 3: pick the division for high or low motor speed.
    logic             r_b3_vld;
    logic [NUM_W-1:0] r_b3_num;
    logic [DEN_W-1:0] r_b3_den;
    logic [11:0]      r_b3_pow;
    logic [14:0]      r_b3_factor;
    logic [8:0]       r_b3_rider;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b3_vld <= 1'b0;
        end else if (en) begin
            r_b3_vld <= r_b2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b3_num    <= r_b2_hi ? {r_b2_phi, 16'd0} : NUM_W'(r_b2_plo);
            r_b3_den    <= r_b2_hi ? r_b2_kr * TWO_PI_Q16 : DEN_W'(i_cfg.battery_voltage);
            r_b3_pow    <= r_b2_pow;
            r_b3_factor <= r_b2_factor;
            r_b3_rider  <= r_b2_rider;
        end
    end

    // Stage 4: flag quotients that exceed 16 bits or a zero divisor.
    logic             r_b4_vld;
    logic [NUM_W-1:0] r_b4_num;
    logic [DEN_W-1:0] r_b4_den;
    logic             r_b4_sat;
    logic [11:0]      r_b4_pow;
    logic [14:0]      r_b4_factor;
    logic [8:0]       r_b4_rider;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b4_vld <= 1'b0;
        end else if (en) begin
            r_b4_vld <= r_b3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b4_num    <= r_b3_num;
            r_b4_den    <= r_b3_den;
            r_b4_sat    <= (r_b3_den == '0) ||
                           ({(DEN_W + QUO_W - NUM_W)'(0), r_b3_num} >= {r_b3_den, 16'd0});
            r_b4_pow    <= r_b3_pow;
            r_b4_factor <= r_b3_factor;
            r_b4_rider  <= r_b3_rider;
        end
    end

    // Divider pipeline for the motor current.
    logic             div_vld;
    logic [QUO_W-1:0] div_q;
    logic [TAG_W-1:0] div_tag;

    pacc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QW    (QUO_W),
        .TAG_W (TAG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b4_vld),
        .i_num   (r_b4_num),
        .i_den   (r_b4_den),
        .i_tag   ({r_b4_pow, r_b4_factor, r_b4_rider, r_b4_sat}),
        .o_valid (div_vld),
        .o_quo   (div_q),
        .o_tag   (div_tag)
    );

    // Stage 5: current limits into the output register.
    logic [11:0] t_pow;
    logic [14:0] t_factor;
    logic [8:0]  t_rider;
    logic        t_sat;
    logic [15:0] n_clamp;
    logic [15:0] n_cur;

    assign {t_pow, t_factor, t_rider, t_sat} = div_tag;

    always_comb begin
        if (t_sat || div_q > i_cfg.max_current) begin
            n_clamp = i_cfg.max_current;
        end else begin
            n_clamp = div_q;
        end
        if (t_pow == '0) begin
            n_cur = '0;
        end else if (i_cfg.max_current != '0 && n_clamp < i_cfg.min_current) begin
            n_cur = i_cfg.min_current;
        end else begin
            n_cur = n_clamp;
        end
    end

    logic [15:0] r_out_cur;
    logic [14:0] r_out_factor;
    logic [8:0]  r_out_rider;
    logic [11:0] r_out_pow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_cur    <= n_cur;
            r_out_factor <= t_factor;
            r_out_rider  <= t_rider;
            r_out_pow    <= t_pow;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_target_current = r_out_cur;
    assign o_assist_factor  = r_out_factor;
    assign o_rider_power    = r_out_rider;
    assign o_assist_power   = r_out_pow;

endmodule
